@@ hw/rtl/sida_pkg.sv @@
package sida_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_BEFORE = 3'd1,
    ST_ACC    = 3'd2,
    ST_AFTER  = 3'd3,
    ST_READ   = 3'd4,
    ST_OVF    = 3'd5,
    ST_CLEAR  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_VAL_RD,
    S_VAL_WR,
    S_SUM_RD,
    S_SUM,
    S_OUT
  } fsm_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/sparse_interval_delta_accumulator.sv @@
// Flow: a clear needs no scan; a read scans every stored interval and reads one value from
// each interval that covers the index; an add scans intervals until one fits and, on an
// insert, shifts the values above the insert point up by one slot.
// Throughput: one request at a time; the next is taken in the cycle after the result is taken.
// Reset: rst_ni asynchronously clears the counts and control state; the memories
// are not cleared and are only read below the counts.
module sparse_interval_delta_accumulator #(
  parameter int MAX_INTERVALS = 64,
  parameter int MAX_VALUES    = 1024,
  parameter int INDEX_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] dense_index_i,
  input  logic signed [31:0] delta_value_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] read_value_o
);

  localparam int IA = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int VA = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int IC = $clog2(MAX_INTERVALS + 1);
  localparam int VC = $clog2(MAX_VALUES + 1);
  localparam int LW = VC;
  localparam int XW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  // A read adds at most one value per interval, so this width never wraps.
  localparam int SW = 32 + IC;
  localparam logic signed [SW-1:0] SUM_HI = SW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SW-1:0] SUM_LO = SW'(-64'sh0000_0000_8000_0000);

  // Interval memory: start and length packed into one word.
  logic [INDEX_BITS+LW-1:0] imem [MAX_INTERVALS];
  logic [INDEX_BITS+LW-1:0] ird_q;
  logic [IA-1:0] iaddr;
  logic          iwe;
  logic [INDEX_BITS+LW-1:0] iwd;

  logic signed [31:0] vmem [MAX_VALUES];
  logic signed [31:0] vrd_q;
  logic [VA-1:0] vaddr;
  logic          vwe;
  logic signed [31:0] vwd;

  always_ff @(posedge clk_i) begin
    if (iwe) begin
      imem[iaddr] <= iwd;
    end
    ird_q <= imem[iaddr];
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vaddr] <= vwd;
    end
    vrd_q <= vmem[vaddr];
  end

  sida_pkg::fsm_e state_q, state_d;
  logic [IC-1:0] icnt_q, icnt_d, i_q, i_d;
  logic [VC-1:0] vcnt_q, vcnt_d, off_q, off_d, pos_q, pos_d, ins_q, ins_d;
  logic [1:0]    req_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic signed [31:0] dlt_q;
  logic [2:0]    st_q, st_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [31:0] rv_q, rv_d;
  logic          ov_q, ov_d;
  logic [INDEX_BITS+LW-1:0] upd_q, upd_d;
  logic          updw_q, updw_d;

  logic [INDEX_BITS-1:0] s_w;
  logic [LW-1:0] l_w;
  logic [INDEX_BITS:0] se_w, idx_e;
  logic [INDEX_BITS+LW:0] end_w;
  logic lo_ok, hi_ok, cov;
  logic req_fire, rsp_fire;

  assign s_w   = ird_q[INDEX_BITS+LW-1:LW];
  assign l_w   = ird_q[LW-1:0];
  assign se_w  = {1'b0, s_w};
  assign idx_e = {1'b0, idx_q};
  assign end_w = (INDEX_BITS+LW+1)'(s_w) + (INDEX_BITS+LW+1)'(l_w);
  assign lo_ok = (s_w == '0) || (se_w - 1'b1 <= idx_e);
  assign hi_ok = end_w >= (INDEX_BITS+LW+1)'(idx_q);
  assign cov   = (s_w <= idx_q) && ((INDEX_BITS+LW+1)'(idx_q) < end_w);

  assign req_ready_o = (state_q == sida_pkg::S_IDLE) && !ov_q;
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = ov_q;
  assign rsp_fire    = ov_q && rsp_ready_i;
  assign status_o    = st_q;
  assign read_value_o = rv_q;

  always_comb begin
    state_d = state_q;
    icnt_d = icnt_q; vcnt_d = vcnt_q; i_d = i_q; off_d = off_q;
    pos_d = pos_q; ins_d = ins_q; st_d = st_q; sum_d = sum_q;
    rv_d = rv_q; ov_d = ov_q; upd_d = upd_q; updw_d = updw_q;
    iaddr = i_q[IA-1:0]; iwe = 1'b0; iwd = upd_q;
    vaddr = pos_q[VA-1:0]; vwe = 1'b0; vwd = vrd_q;
    if (rsp_fire) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      sida_pkg::S_IDLE: begin
        if (req_fire && req_type_i != sida_pkg::REQ_NONE) begin
          i_d = '0; off_d = '0; sum_d = '0; rv_d = '0; updw_d = 1'b0;
          if (req_type_i == sida_pkg::REQ_CLEAR) begin
            icnt_d = '0; vcnt_d = '0;
            st_d = sida_pkg::ST_CLEAR;
            state_d = sida_pkg::S_OUT;
          end else begin
            state_d = sida_pkg::S_SCAN_RD;
          end
        end
      end
      sida_pkg::S_SCAN_RD: begin
        if (i_q == icnt_q) begin
          if (req_q == sida_pkg::REQ_READ) begin
            if (sum_q > SUM_HI) begin
              rv_d = 32'sh7FFF_FFFF;
            end else if (sum_q < SUM_LO) begin
              rv_d = 32'sh8000_0000;
            end else begin
              rv_d = sum_q[31:0];
            end
            st_d = sida_pkg::ST_READ;
            state_d = sida_pkg::S_OUT;
          end else if (icnt_q == IC'(MAX_INTERVALS) || vcnt_q == VC'(MAX_VALUES)) begin
            st_d = sida_pkg::ST_OVF;
            state_d = sida_pkg::S_OUT;
          end else begin
            st_d = sida_pkg::ST_NEW;
            upd_d = {idx_q, LW'(1)};
            updw_d = 1'b1;
            icnt_d = icnt_q + 1'b1;
            ins_d = vcnt_q;
            pos_d = vcnt_q;
            state_d = sida_pkg::S_SHIFT_RD;
          end
        end else begin
          state_d = sida_pkg::S_SCAN;
        end
      end
      sida_pkg::S_SCAN: begin
        if (req_q == sida_pkg::REQ_READ) begin
          if (cov) begin
            pos_d = off_q + VC'(idx_q - s_w);
            state_d = sida_pkg::S_SUM_RD;
          end else begin
            off_d = off_q + l_w;
            i_d = i_q + 1'b1;
            state_d = sida_pkg::S_SCAN_RD;
          end
        end else if (lo_ok && hi_ok) begin
          if (s_w != '0 && s_w - 1'b1 == idx_q) begin
            if (vcnt_q == VC'(MAX_VALUES)) begin
              st_d = sida_pkg::ST_OVF; state_d = sida_pkg::S_OUT;
            end else begin
              st_d = sida_pkg::ST_BEFORE;
              upd_d = {idx_q, l_w + 1'b1}; updw_d = 1'b1;
              ins_d = off_q; pos_d = vcnt_q;
              state_d = sida_pkg::S_SHIFT_RD;
            end
          end else if (cov) begin
            st_d = sida_pkg::ST_ACC;
            pos_d = off_q + VC'(idx_q - s_w);
            state_d = sida_pkg::S_VAL_RD;
          end else if (vcnt_q == VC'(MAX_VALUES)) begin
            st_d = sida_pkg::ST_OVF; state_d = sida_pkg::S_OUT;
          end else begin
            st_d = sida_pkg::ST_AFTER;
            upd_d = {s_w, l_w + 1'b1}; updw_d = 1'b1;
            ins_d = off_q + l_w; pos_d = vcnt_q;
            state_d = sida_pkg::S_SHIFT_RD;
          end
        end else begin
          off_d = off_q + l_w;
          i_d = i_q + 1'b1;
          state_d = sida_pkg::S_SCAN_RD;
        end
      end
      // Move values up one slot from the top down to the insert point.
      sida_pkg::S_SHIFT_RD: begin
        if (pos_q == ins_q) begin
          vwe = 1'b1; vwd = dlt_q;
          vcnt_d = vcnt_q + 1'b1;
          iwe = updw_q;
          state_d = sida_pkg::S_OUT;
        end else begin
          vaddr = VA'(pos_q - 1'b1);
          state_d = sida_pkg::S_SHIFT_WR;
        end
      end
      sida_pkg::S_SHIFT_WR: begin
        vwe = 1'b1;
        pos_d = pos_q - 1'b1;
        state_d = sida_pkg::S_SHIFT_RD;
      end
      sida_pkg::S_VAL_RD: begin
        state_d = sida_pkg::S_VAL_WR;
      end
      sida_pkg::S_VAL_WR: begin
        vwe = 1'b1;
        vwd = sida_pkg::sat32(34'(vrd_q) + 34'(dlt_q));
        state_d = sida_pkg::S_OUT;
      end
      sida_pkg::S_SUM_RD: begin
        state_d = sida_pkg::S_SUM;
      end
      sida_pkg::S_SUM: begin
        sum_d = sum_q + SW'(vrd_q);
        off_d = off_q + l_w;
        i_d = i_q + 1'b1;
        state_d = sida_pkg::S_SCAN_RD;
      end
      sida_pkg::S_OUT: begin
        ov_d = 1'b1;
        state_d = sida_pkg::S_IDLE;
      end
      default: state_d = sida_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sida_pkg::S_IDLE;
      icnt_q <= '0; vcnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      icnt_q <= icnt_d; vcnt_q <= vcnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; off_q <= off_d; pos_q <= pos_d; ins_q <= ins_d;
    st_q <= st_d; rv_q <= rv_d; upd_q <= upd_d; updw_q <= updw_d;
    sum_q <= sum_d;
    if (req_fire) begin
      req_q <= req_type_i;
      idx_q <= INDEX_BITS'(dense_index_i[XW-1:0]);
      dlt_q <= delta_value_i;
    end
  end

endmodule

@@ hw/rtl/sida_checker.sv @@
module sida_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_o,
  input logic        rsp_valid_o,
  input logic        rsp_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] read_value_o
);

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> status_o != 3'd7) else $error("bad status");
  a_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && status_o != sida_pkg::ST_READ |-> read_value_o == '0)
    else $error("nonzero value");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(status_o))
    else $error("result dropped");

endmodule

bind sparse_interval_delta_accumulator sida_checker u_sida_checker (.*);

@@ bench/sparse_interval_delta_accumulator_test.sv @@
module sparse_interval_delta_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_INTERVALS = 64;
  localparam int NUM_VALUES    = 1024;
  localparam int CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    sida_pkg::req_e     kind;
    logic [15:0]        index;
    logic signed [31:0] delta;
  } request_t;

  typedef struct packed {
    sida_pkg::status_e  status;
    logic signed [31:0] value;
  } answer_t;

  logic clk_i;
  logic rst_ni;
  logic req_valid;
  logic req_ready_o;
  sida_pkg::req_e req_type;
  logic [15:0] dense_index;
  logic signed [31:0] delta_value;
  logic rsp_valid_o;
  logic rsp_ready;
  logic [2:0] status_o;
  logic signed [31:0] read_value_o;

  sparse_interval_delta_accumulator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_valid_i          (req_valid),
    .req_ready_o          (req_ready_o),
    .req_type_i           (req_type),
    .dense_index_i        (dense_index),
    .delta_value_i        (delta_value),
    .rsp_valid_o          (rsp_valid_o),
    .rsp_ready_i          (rsp_ready),
    .status_o             (status_o),
    .read_value_o         (read_value_o)
  );

  // Shadow copy of the interval list and the packed value store.
  int unsigned        span_start[$];
  int unsigned        span_len[$];
  logic signed [31:0] packed_vals[$];

  request_t pending[$];
  answer_t  expected_answers[$];
  int errors;
  int checked;
  int accepted;
  int cycles;
  int status_seen[7];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void predict_request(request_t r);
    answer_t a;
    int unsigned ix;
    int unsigned off;
    int unsigned s;
    int unsigned l;
    int hit;
    longint total;
    ix = r.index;
    off = 0;
    hit = -1;
    a.value = '0;
    case (r.kind)
      sida_pkg::REQ_NONE: return;
      sida_pkg::REQ_CLEAR: begin
        span_start.delete();
        span_len.delete();
        packed_vals.delete();
        a.status = sida_pkg::ST_CLEAR;
      end
      sida_pkg::REQ_READ: begin
        total = 0;
        foreach (span_start[i]) begin
          if (span_start[i] <= ix && ix < span_start[i] + span_len[i])
            total += packed_vals[off + ix - span_start[i]];
          off += span_len[i];
        end
        a.value = clamp32(total);
        a.status = sida_pkg::ST_READ;
      end
      default: begin
        foreach (span_start[i]) begin
          if (hit < 0) begin
            s = span_start[i];
            if ((s == 0 || s - 1 <= ix) && s + span_len[i] >= ix) hit = i;
            else off += span_len[i];
          end
        end
        if (hit < 0) begin
          if (span_start.size() >= NUM_INTERVALS || packed_vals.size() >= NUM_VALUES) begin
            a.status = sida_pkg::ST_OVF;
          end else begin
            packed_vals.push_back(r.delta);
            span_start.push_back(ix);
            span_len.push_back(1);
            a.status = sida_pkg::ST_NEW;
          end
        end else begin
          s = span_start[hit];
          l = span_len[hit];
          if (s > 0 && s - 1 == ix) begin
            if (packed_vals.size() >= NUM_VALUES) begin
              a.status = sida_pkg::ST_OVF;
            end else begin
              span_start[hit] = s - 1;
              span_len[hit] = l + 1;
              packed_vals.insert(off, r.delta);
              a.status = sida_pkg::ST_BEFORE;
            end
          end else if (s <= ix && ix < s + l) begin
            packed_vals[off + ix - s] =
              clamp32(longint'(packed_vals[off + ix - s]) + longint'(r.delta));
            a.status = sida_pkg::ST_ACC;
          end else if (packed_vals.size() >= NUM_VALUES) begin
            a.status = sida_pkg::ST_OVF;
          end else begin
            span_len[hit] = l + 1;
            packed_vals.insert(off + l, r.delta);
            a.status = sida_pkg::ST_AFTER;
          end
        end
      end
    endcase
    expected_answers.push_back(a);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_request(sida_pkg::req_e k, int unsigned ix,
                                       logic signed [31:0] d);
    request_t r;
    r.kind = k;
    r.index = ix[15:0];
    r.delta = d;
    pending.push_back(r);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: holds the payload steady until the handshake completes.
  int send_gap;
  request_t next_req;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_type <= sida_pkg::REQ_NONE;
      dense_index <= '0;
      delta_value <= '0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ready_o) begin
        next_req.kind = req_type;
        next_req.index = dense_index;
        next_req.delta = delta_value;
        predict_request(next_req);
        accepted++;
      end
      if (!req_valid || req_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          next_req = pending.pop_front();
          req_valid <= 1'b1;
          req_type <= next_req.kind;
          dense_index <= next_req.index;
          delta_value <= next_req.delta;
          send_gap = pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  answer_t want;
  int ready_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (rsp_valid_o && rsp_ready) begin
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: status %0d value %0d", status_o, read_value_o);
        end else begin
          want = expected_answers.pop_front();
          checked++;
          if (status_o < 7) status_seen[status_o]++;
          if (status_o !== want.status || read_value_o !== want.value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
                       want.status, status_o, want.value, read_value_o);
          end
        end
        ready_gap = pick_gap();
      end
      if (ready_gap > 0) begin
        ready_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, expected_answers.size());
      $display("sparse_interval_delta_accumulator_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned ix;
    int roll;
    logic signed [31:0] d;
    errors = 0;
    checked = 0;
    accepted = 0;
    cycles = 0;
    rst_ni = 1'b0;

    // Directed: edges of the index range, growth both ways, saturation,
    // overlapping intervals and the unused request code.
    queue_request(sida_pkg::REQ_READ, 16'd5, 32'sd0);
    queue_request(sida_pkg::REQ_ADD, 16'd0, 32'sh7FFF_FFFF);
    queue_request(sida_pkg::REQ_ADD, 16'd0, 32'sh7FFF_FFFF);
    queue_request(sida_pkg::REQ_ADD, 16'd1, 32'sh8000_0000);
    queue_request(sida_pkg::REQ_ADD, 16'd1, 32'sh8000_0000);
    queue_request(sida_pkg::REQ_ADD, 16'hFFFF, 32'sh0001_0000);
    queue_request(sida_pkg::REQ_ADD, 16'hFFFE, -32'sh0000_8000);
    queue_request(sida_pkg::REQ_READ, 16'hFFFF, 32'sh1234_5678);
    queue_request(sida_pkg::REQ_NONE, 16'd7, 32'sd9);
    queue_request(sida_pkg::REQ_CLEAR, 16'hABCD, 32'sh5555_AAAA);
    queue_request(sida_pkg::REQ_ADD, 16'd10, 32'sh7FFF_FFFF);
    queue_request(sida_pkg::REQ_ADD, 16'd12, 32'sh7FFF_FFFF);
    queue_request(sida_pkg::REQ_ADD, 16'd11, 32'sd0);
    queue_request(sida_pkg::REQ_ADD, 16'd12, 32'sh7FFF_FFFF);
    queue_request(sida_pkg::REQ_READ, 16'd12, 32'sd0);
    queue_request(sida_pkg::REQ_ADD, 16'd9, 32'sh8000_0000);
    queue_request(sida_pkg::REQ_READ, 16'd9, 32'sd0);
    queue_request(sida_pkg::REQ_READ, 16'd11, 32'sd0);
    queue_request(sida_pkg::REQ_READ, 16'd40, 32'sd0);
    queue_request(sida_pkg::REQ_CLEAR, 16'd0, 32'sd0);

    // Fill the interval list until adds overflow.
    for (int k = 0; k < 67; k++) queue_request(sida_pkg::REQ_ADD, 100 + 3 * k, $urandom());
    queue_request(sida_pkg::REQ_ADD, 101, 32'sd3);
    queue_request(sida_pkg::REQ_READ, 103, 32'sd0);
    queue_request(sida_pkg::REQ_CLEAR, 16'd0, 32'sd0);

    // Random part: adds clustered in a window so intervals grow and overlap,
    // reads always inside the window, rare clears and noise.
    base = $urandom_range(0, 65535);
    for (int k = 0; k < 440; k++) begin
      roll = $urandom_range(0, 99);
      ix = (base + $urandom_range(0, 40)) & 16'hFFFF;
      d = ($urandom_range(0, 9) == 0) ? $urandom() : $signed($urandom_range(0, 65535)) - 32768;
      if (roll < 2) begin
        queue_request(sida_pkg::REQ_CLEAR, $urandom(), $urandom());
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(65500, 65535)
                                           : $urandom_range(0, 65535);
      end else if (roll < 4) begin
        queue_request(sida_pkg::REQ_NONE, $urandom(), $urandom());
      end else if (roll < 8) begin
        queue_request(sida_pkg::REQ_ADD, $urandom(), $urandom());
      end else if (roll < 33) begin
        queue_request(sida_pkg::REQ_READ, ix, $urandom());
      end else begin
        queue_request(sida_pkg::REQ_ADD, ix, d);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending.size() == 0 && !req_valid && expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d requests accepted, %0d responses checked in %0d cycles", accepted, checked,
             cycles);
    $display("new %0d, grown before %0d, accumulated %0d, grown after %0d,",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("read %0d, overflow %0d, clear %0d",
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("sparse_interval_delta_accumulator_test: done, clean");
    end else begin
      $display("%0d errors, %0d responses never arrived", errors, expected_answers.size());
      $display("sparse_interval_delta_accumulator_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sida_pkg.sv
hw/rtl/sparse_interval_delta_accumulator.sv
hw/rtl/sida_checker.sv
bench/sparse_interval_delta_accumulator_test.sv
